### hw/rtl/tile_dominant_color_macros.svh
// assertion macros for the tile dominant colour block
`ifndef TILE_DOMINANT_COLOR_MACROS_SVH
`define TILE_DOMINANT_COLOR_MACROS_SVH

`ifndef SYNTH
`define TDC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdc assertion failed");
`define TDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdc assertion failed");
`else
`define TDC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TDC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/tdc_pkg.sv
// shared types and constants of the tile dominant colour block
package tdc_pkg;

   localparam int COLOR_W = 32;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 7'd1;

   typedef struct packed {
      logic               valid;
      logic               skip;
      logic               last;
      logic [COLOR_W-1:0] color;
      logic               hit;
      logic [COUNT_W-1:0] count;
   } word_type;

endpackage

### hw/rtl/tdc_cell.sv
// one table entry of the colour chain: match, claim, count and clear
module tdc_cell
   import tdc_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  word_type         word_i,
   input  logic [IDX_W-1:0] slot_i,
   output word_type         word_o,
   output logic [IDX_W-1:0] slot_o
);

   word_type           word_ff, word_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               valid_ff, valid_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               use_word;

   always_comb begin
      word_in  = word_i;
      slot_in  = slot_i;
      valid_in = valid_ff;
      color_in = color_ff;
      count_in = count_ff;
      use_word = word_i.valid && !word_i.skip && !word_i.hit;
      if (use_word) begin
         if (valid_ff && (color_ff == word_i.color)) begin
            count_in      = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;
            word_in.hit   = 1'b1;
            word_in.count = count_in;
            slot_in       = IDX_W'(INDEX);
         end else if (!valid_ff) begin
            valid_in      = 1'b1;
            color_in      = word_i.color;
            count_in      = COUNT_ONE;
            word_in.hit   = 1'b1;
            word_in.count = COUNT_ONE;
            slot_in       = IDX_W'(INDEX);
         end
      end
      // end of tile empties the entry once this word has passed
      if (word_i.valid && word_i.last) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         word_ff.valid <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         word_ff.valid <= word_in.valid;
      end
      word_ff.skip  <= word_in.skip;
      word_ff.last  <= word_in.last;
      word_ff.color <= word_in.color;
      word_ff.hit   <= word_in.hit;
      word_ff.count <= word_in.count;
      slot_ff       <= slot_in;
      color_ff      <= color_in;
      count_ff      <= count_in;
   end

   assign word_o = word_ff;
   assign slot_o = slot_ff;

endmodule

### hw/rtl/tdc_leader.sv
// leader tracking at the chain end and the registered result
module tdc_leader
   import tdc_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  word_type           word_i,
   input  logic [IDX_W-1:0]   slot_i,
   input  logic [COLOR_W-1:0] fallback_color,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] rsp_dominant_color,
   output logic [COUNT_W-1:0] rsp_dominant_count,
   output logic               rsp_used_fallback
);

   `include "tile_dominant_color_macros.svh"

   logic               lead_valid_ff, lead_valid_in;
   logic [IDX_W-1:0]   lead_idx_ff, lead_idx_in;
   logic [COUNT_W-1:0] lead_cnt_ff, lead_cnt_in;
   logic [COLOR_W-1:0] lead_color_ff, lead_color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_fallback_ff, rsp_fallback_in;

   always_comb begin
      lead_valid_in   = lead_valid_ff;
      lead_idx_in     = lead_idx_ff;
      lead_cnt_in     = lead_cnt_ff;
      lead_color_in   = lead_color_ff;
      rsp_valid_in    = 1'b0;
      rsp_color_in    = rsp_color_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_fallback_in = rsp_fallback_ff;
      if (word_i.valid && !word_i.skip && word_i.hit) begin
         if (!lead_valid_ff || (word_i.count > lead_cnt_ff)) begin
            lead_valid_in = 1'b1;
            lead_idx_in   = slot_i;
            lead_cnt_in   = word_i.count;
            lead_color_in = word_i.color;
         end else if (slot_i == lead_idx_ff) begin
            lead_cnt_in = word_i.count;
         end
      end
      if (word_i.valid && word_i.last) begin
         rsp_valid_in = 1'b1;
         if (lead_valid_in) begin
            rsp_color_in    = lead_color_in;
            rsp_count_in    = lead_cnt_in;
            rsp_fallback_in = 1'b0;
         end else begin
            rsp_color_in    = fallback_color;
            rsp_count_in    = '0;
            rsp_fallback_in = 1'b1;
         end
         lead_valid_in = 1'b0;
         lead_idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_valid_ff <= 1'b0;
         lead_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lead_valid_ff <= lead_valid_in;
         lead_idx_ff   <= lead_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lead_cnt_ff     <= lead_cnt_in;
      lead_color_ff   <= lead_color_in;
      rsp_color_ff    <= rsp_color_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_fallback_ff <= rsp_fallback_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dominant_color = rsp_color_ff;
   assign rsp_dominant_count = rsp_count_ff;
   assign rsp_used_fallback  = rsp_fallback_ff;

   `TDC_ASSERT_SAME(a_fallback_zero, clock, reset, rsp_valid_ff,
                    rsp_fallback_ff == (rsp_count_ff == '0))
   `TDC_ASSERT_SAME(a_cleared_after_rsp, clock, reset, rsp_valid_ff, !lead_valid_ff)
   `TDC_ASSERT_SAME(a_leader_counted, clock, reset, lead_valid_ff, lead_cnt_ff != '0)
   `TDC_ASSERT_NEXT(a_last_gives_rsp, clock, reset, word_i.valid && word_i.last,
                    rsp_valid_ff)

endmodule

### hw/rtl/tile_dominant_color.sv
// top level of the tile dominant colour block: cell chain and leader stage
// a word reaches its result strobe through every cell register, then the leader register
// throughput: one pixel word per cycle while busy is low, set by the cell register chain
// results are a single-cycle strobe on rsp_valid; the receiver cannot stall
// reset: synchronous, clears every entry, the leader and the fallback colour
// busy is high while reset is held and in the cycle after it is released
module tile_dominant_color
   import tdc_pkg::*;
#(
   parameter int NUM_SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [COLOR_W-1:0] req_pixel_color,
   input  logic               req_pixel_skipped,
   input  logic               req_last_pixel,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] rsp_dominant_color,
   output logic [COUNT_W-1:0] rsp_dominant_count,
   output logic               rsp_used_fallback,
   input  logic               csr_we,
   input  logic [COLOR_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   word_type           word_chain [0:NUM_SLOTS];
   logic [IDX_W-1:0]   slot_chain [0:NUM_SLOTS];
   logic               busy_ff;
   logic [COLOR_W-1:0] fallback_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         fallback_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            fallback_ff <= csr_wdata;
         end
      end
   end

   assign busy = busy_ff;

   always_comb begin
      word_chain[0].valid = start && !busy_ff;
      word_chain[0].skip  = req_pixel_skipped;
      word_chain[0].last  = req_last_pixel;
      word_chain[0].color = req_pixel_color;
      word_chain[0].hit   = 1'b0;
      word_chain[0].count = '0;
      slot_chain[0]       = '0;
   end

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      tdc_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .word_i (word_chain[i]),
         .slot_i (slot_chain[i]),
         .word_o (word_chain[i+1]),
         .slot_o (slot_chain[i+1])
      );
   end

   tdc_leader #(
      .IDX_W (IDX_W)
   ) u_leader (
      .clock              (clock),
      .reset              (reset),
      .word_i             (word_chain[NUM_SLOTS]),
      .slot_i             (slot_chain[NUM_SLOTS]),
      .fallback_color     (fallback_ff),
      .rsp_valid          (rsp_valid),
      .rsp_dominant_color (rsp_dominant_color),
      .rsp_dominant_count (rsp_dominant_count),
      .rsp_used_fallback  (rsp_used_fallback)
   );

endmodule

### verif/tb_tile_dominant_color.sv
`timescale 1ns / 1ps
// self-checking testbench of the tile dominant colour block: scoreboard, drivers, stimulus
module tb_tile_dominant_color
   import tdc_pkg::*;
();

   localparam int NUM_SLOTS = 64;
   localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic [COUNT_W-1:0] count;
      logic               fallback;
   } tile_result_type;

   class dominant_color_board_type;
      logic [COLOR_W-1:0] fallback_color;
      logic [COLOR_W-1:0] colors [NUM_SLOTS];
      logic [COUNT_W-1:0] counts [NUM_SLOTS];
      int unsigned        distinct;
      int unsigned        lead;
      bit                 lead_ok;
      tile_result_type    tiles_due [$];
      int unsigned        failures;
      int unsigned        tiles_checked;
      int unsigned        fallback_tiles;

      function new();
         fallback_color = '0;
         failures = 0;
         tiles_checked = 0;
         fallback_tiles = 0;
         clear_tile();
      endfunction

      function void clear_tile();
         foreach (counts[i]) counts[i] = '0;
         distinct = 0;
         lead = 0;
         lead_ok = 1'b0;
      endfunction

      function int unsigned pending();
         return tiles_due.size();
      endfunction

      function void note_pixel(logic [COLOR_W-1:0] color, logic skip, logic last);
         int unsigned     slot;
         bit              slot_ok;
         tile_result_type due;
         slot = 0;
         slot_ok = 1'b0;
         if (!skip) begin
            for (int unsigned i = 0; i < distinct; i++) begin
               if (!slot_ok && colors[i] == color) begin
                  slot = i;
                  slot_ok = 1'b1;
               end
            end
            // a new colour is dropped once the table is full
            if (!slot_ok && distinct < NUM_SLOTS) begin
               slot = distinct;
               colors[slot] = color;
               counts[slot] = '0;
               distinct++;
               slot_ok = 1'b1;
            end
            if (slot_ok) begin
               if (counts[slot] != COUNT_MAX) counts[slot] = counts[slot] + COUNT_ONE;
               if (!lead_ok || counts[slot] > counts[lead]) begin
                  lead = slot;
                  lead_ok = 1'b1;
               end
            end
         end
         if (last) begin
            if (lead_ok) begin
               due.color = colors[lead];
               due.count = counts[lead];
               due.fallback = 1'b0;
            end else begin
               due.color = fallback_color;
               due.count = '0;
               due.fallback = 1'b1;
            end
            tiles_due.push_back(due);
            clear_tile();
         end
      endfunction

      function void check_result(logic [COLOR_W-1:0] color, logic [COUNT_W-1:0] count,
                                 logic fallback);
         tile_result_type due;
         if (tiles_due.size() == 0) begin
            $error("result word with no tile waiting: colour %h count %0d fallback %b",
                   color, count, fallback);
            failures++;
            return;
         end
         due = tiles_due.pop_front();
         tiles_checked++;
         if (due.fallback) fallback_tiles++;
         if (color !== due.color) begin
            $error("dominant_color: expected %h, got %h", due.color, color);
            failures++;
         end
         if (count !== due.count) begin
            $error("dominant_count: expected %0d, got %0d", due.count, count);
            failures++;
         end
         if (fallback !== due.fallback) begin
            $error("used_fallback: expected %b, got %b", due.fallback, fallback);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [COLOR_W-1:0] req_pixel_color = '0;
   logic               req_pixel_skipped = 1'b0;
   logic               req_last_pixel = 1'b0;
   logic               rsp_valid;
   logic [COLOR_W-1:0] rsp_dominant_color;
   logic [COUNT_W-1:0] rsp_dominant_count;
   logic               rsp_used_fallback;
   logic               csr_we = 1'b0;
   logic [COLOR_W-1:0] csr_wdata = '0;

   dominant_color_board_type board;
   int unsigned idle_pct = 0;
   int unsigned words_sent = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles = 0;

   tile_dominant_color #(.NUM_SLOTS(NUM_SLOTS)) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pixel_color   (req_pixel_color),
      .req_pixel_skipped (req_pixel_skipped),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_dominant_color(rsp_dominant_color),
      .rsp_dominant_count(rsp_dominant_count),
      .rsp_used_fallback (rsp_used_fallback),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // results are checked before the word accepted at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_dominant_color, rsp_dominant_count,
                                           rsp_used_fallback);
         if (start && !busy) board.note_pixel(req_pixel_color, req_pixel_skipped,
                                              req_last_pixel);
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without traffic", quiet_cycles);
            $display("tile_dominant_color verification failed");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [COLOR_W-1:0] color, input logic skip,
                            input logic last);
      start <= 1'b1;
      req_pixel_color <= color;
      req_pixel_skipped <= skip;
      req_last_pixel <= last;
      do @(posedge clock); while (busy);
      words_sent++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
   endtask

   // wait for every tile result, then let the cell chain empty
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fallback(input logic [COLOR_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      board.fallback_color = value;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic random_tile();
      logic [COLOR_W-1:0] palette [4];
      logic [COLOR_W-1:0] color;
      int unsigned        len;
      int unsigned        shape;
      int unsigned        n_colors;
      int unsigned        skip_pct;
      shape = $urandom_range(99);
      n_colors = $urandom_range(1, 4);
      foreach (palette[i]) palette[i] = $urandom();
      if (shape < 15) begin
         len = $urandom_range(1, 4);
         skip_pct = 100;
      end else if (shape < 30) begin
         len = $urandom_range(13, 40);
         skip_pct = 20;
      end else begin
         len = $urandom_range(1, 12);
         skip_pct = 25;
      end
      for (int unsigned k = 0; k < len; k++) begin
         color = ($urandom_range(9) == 0) ? $urandom() : palette[$urandom_range(n_colors - 1)];
         send_word(color, $urandom_range(99) < skip_pct, k == len - 1);
      end
   endtask

   // fills all entries, then offers colours that must be dropped
   task automatic overfull_tile();
      logic [23:0] stem;
      stem = $urandom();
      for (int k = 0; k < NUM_SLOTS; k++) send_word({stem, k[7:0]}, 1'b0, 1'b0);
      send_word({stem, 8'd5}, 1'b0, 1'b0);
      send_word({stem, 8'd5}, 1'b0, 1'b0);
      for (int k = 0; k < 4; k++) send_word({stem, 8'h80 + k[7:0]}, 1'b0, 1'b0);
      repeat (4) send_word({stem, 8'hC0}, 1'b0, 1'b0);
      send_word({stem, 8'hC0}, 1'b1, 1'b1);
   endtask

   // both colours reach the ceiling, the first keeps the lead
   task automatic saturating_tile();
      logic [COLOR_W-1:0] first_color;
      first_color = $urandom();
      repeat (130) send_word(first_color, 1'b0, 1'b0);
      repeat (131) send_word(~first_color, 1'b0, 1'b0);
      send_word(~first_color, 1'b0, 1'b1);
   endtask

   initial begin
      int unsigned phase_start;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all skipped straight after reset gives the reset background colour
      send_word(32'h1234_5678, 1'b1, 1'b1);
      settle();
      write_fallback(32'hFFFF_FFFF);
      // tie between two colours keeps the earlier one
      send_word(32'h0000_0000, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_word(32'h0000_0000, 1'b1, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_word(32'hA5A5_A5A5, 1'b1, 1'b0);
      send_word(32'h5A5A_5A5A, 1'b1, 1'b1);
      send_word(32'h0F0F_F0F0, 1'b0, 1'b1);
      send_word(32'h8000_0001, 1'b0, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b0, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b0, 1'b0);
      send_word(32'h8000_0001, 1'b0, 1'b1);
      send_word(32'h8000_0001, 1'b0, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b0, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b0, 1'b0);
      send_word(32'h8000_0001, 1'b0, 1'b0);
      send_word(32'h8000_0001, 1'b0, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         settle();
         case (phase)
            0: begin
               write_fallback($urandom());
               idle_pct = 25;
            end
            1: begin
               write_fallback(32'h0000_0000);
               idle_pct = 55;
            end
            default: begin
               write_fallback($urandom());
               idle_pct = 0;
            end
         endcase
         phase_start = words_sent;
         if (phase == 0) overfull_tile();
         if (phase == 1) saturating_tile();
         while (words_sent - phase_start < 95 + ((phase == 1) ? 262 : 0)
                                              + ((phase == 0) ? 75 : 0)) begin
            if ($urandom_range(24) == 0) begin
               settle();
               write_fallback($urandom());
            end
            random_tile();
         end
      end

      settle();
      $display("run covered %0d pixel words and %0d tiles, %0d on the background colour",
               words_sent, board.tiles_checked, board.fallback_tiles);
      $display("with %0d background settings, a table overflow and a count ceiling tile",
               settings_used);
      if (board.failures == 0) begin
         $display("tile_dominant_color verification clean");
      end else begin
         $display("tile_dominant_color verification failed");
      end
      $finish;
   end

endmodule
